>>> sv/ils_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the indexed list store.
// No dependencies; every other file of the block uses this package.
package ils_pkg;

   localparam int DEPTH_DEFAULT     = 16;
   localparam int WORD_BITS_DEFAULT = 32;

   localparam int KIND_BITS   = 4;
   localparam int DATA_BITS   = 32;
   localparam int INDEX_BITS  = 5;
   localparam int COUNT_BITS  = 5;
   localparam int STATUS_BITS = 2;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_PUSH_FRONT = 4'd0,
      KIND_PUSH_BACK  = 4'd1,
      KIND_INSERT     = 4'd2,
      KIND_REMOVE_AT  = 4'd3,
      KIND_POP_FRONT  = 4'd4,
      KIND_POP_BACK   = 4'd5,
      KIND_READ_AT    = 4'd6,
      KIND_CONTAINS   = 4'd7,
      KIND_CLEAR      = 4'd8
   } kind_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      SHIFT_HOLD  = 2'd0,
      SHIFT_OPEN  = 2'd1,
      SHIFT_CLOSE = 2'd2
   } shift_op_type;

   typedef struct packed {
      logic sel;
      logic eq;
   } cell_status_type;

endpackage

>>> sv/ils_req_if.sv
`timescale 1ns / 1ps
// Request channel of the indexed list store: valid/ready plus one operation word.
// Depends on ils_pkg for the field widths.
interface ils_req_if;
   logic                          valid;
   logic                          ready;
   logic [ils_pkg::KIND_BITS-1:0] kind;
   logic signed [ils_pkg::DATA_BITS-1:0] value;
   logic [ils_pkg::INDEX_BITS-1:0] index;

   modport source (output valid, output kind, output value, output index, input ready);
   modport sink (input valid, input kind, input value, input index, output ready);
endinterface

>>> sv/ils_rsp_if.sv
`timescale 1ns / 1ps
// Response channel of the indexed list store: valid/ready plus one result word.
// Depends on ils_pkg for the field widths.
interface ils_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [ils_pkg::DATA_BITS-1:0] read_data;
   logic                                 found;
   logic [ils_pkg::COUNT_BITS-1:0]       count;
   logic [ils_pkg::STATUS_BITS-1:0]      status;

   modport source (output valid, output read_data, output found, output count,
                   output status, input ready);
   modport sink (input valid, input read_data, input found, input count,
                 input status, output ready);
endinterface

>>> sv/ils_cell.sv
`timescale 1ns / 1ps
// One slot of the list: holds a word, shifts with its neighbors and reports matches.
// Depends on ils_pkg for the shift command and status types.
module ils_cell #(
   parameter int WORD_BITS = ils_pkg::WORD_BITS_DEFAULT,
   parameter int POS_BITS  = ils_pkg::INDEX_BITS,
   parameter int POS       = 0
) (
   input  logic                          clock,
   input  ils_pkg::shift_op_type         op,
   input  logic [POS_BITS-1:0]           pos,
   input  logic [POS_BITS-1:0]           occupancy,
   input  logic [POS_BITS-1:0]           index,
   input  logic [WORD_BITS-1:0]          new_word,
   input  logic [WORD_BITS-1:0]          key,
   input  logic [WORD_BITS-1:0]          left_word,
   input  logic [WORD_BITS-1:0]          right_word,
   output logic [WORD_BITS-1:0]          word,
   output ils_pkg::cell_status_type      status
);

   localparam logic [POS_BITS-1:0] MY_POS = POS_BITS'(POS);

   logic [WORD_BITS-1:0] word_ff;
   logic [WORD_BITS-1:0] word_in;

   always_comb begin
      word_in = word_ff;
      unique case (op)
         ils_pkg::SHIFT_OPEN: begin
            if (MY_POS > pos) begin
               word_in = left_word;
            end else if (MY_POS == pos) begin
               word_in = new_word;
            end
         end
         ils_pkg::SHIFT_CLOSE: begin
            if (MY_POS >= pos) begin
               word_in = right_word;
            end
         end
         default: begin
            word_in = word_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word       = word_ff;
   assign status.sel = (MY_POS == index);
   assign status.eq  = (MY_POS < occupancy) && (word_ff == key);

endmodule

>>> sv/indexed_list_store.sv
`timescale 1ns / 1ps
// Indexed list store: an ordered list of up to DEPTH words in a row of shifting slots.
// Every operation, including insert, remove and search, acts on all slots at once;
// the response is registered and appears in the cycle after the request word is taken,
// and a new request word is taken every cycle while the response register is free or being drained.
// Reset clears the count and the response valid; slot contents are not cleared.
// Depends on ils_pkg, ils_req_if, ils_rsp_if and ils_cell.
module indexed_list_store #(
   parameter int DEPTH     = ils_pkg::DEPTH_DEFAULT,
   parameter int WORD_BITS = ils_pkg::WORD_BITS_DEFAULT
) (
   input logic     clock,
   input logic     reset,
   ils_req_if.sink   req_chan,
   ils_rsp_if.source rsp_chan
);

   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam int CMP_BITS = (CNT_BITS > ils_pkg::INDEX_BITS) ? CNT_BITS
                                                              : ils_pkg::INDEX_BITS;
   localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(DEPTH);

   logic [CNT_BITS-1:0] occ_ff;
   logic [CNT_BITS-1:0] occ_in;

   logic                                 rsp_valid_ff;
   logic signed [ils_pkg::DATA_BITS-1:0] rsp_data_ff;
   logic signed [ils_pkg::DATA_BITS-1:0] rsp_data_in;
   logic                                 rsp_found_ff;
   logic                                 rsp_found_in;
   logic [ils_pkg::COUNT_BITS-1:0]       rsp_count_ff;
   logic [ils_pkg::STATUS_BITS-1:0]      rsp_status_ff;
   ils_pkg::status_type                  status_in;

   logic                  accept;
   logic [CMP_BITS-1:0]   idx_ext;
   logic [CMP_BITS-1:0]   occ_ext;
   logic                  full;
   logic                  empty;
   ils_pkg::shift_op_type op_c;
   ils_pkg::shift_op_type cell_op;
   logic [CMP_BITS-1:0]   pos_c;
   logic                  read_ok;

   logic [WORD_BITS-1:0]         key_word;
   logic [WORD_BITS-1:0]         rd_word;
   logic [ils_pkg::DATA_BITS-1:0] rd_data;
   logic                         any_eq;

   logic [WORD_BITS-1:0]     cell_word [DEPTH];
   ils_pkg::cell_status_type cell_stat [DEPTH];

   assign accept         = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;

   assign idx_ext = CMP_BITS'(req_chan.index);
   assign occ_ext = CMP_BITS'(occ_ff);
   assign full    = (occ_ff == FULL_COUNT);
   assign empty   = (occ_ff == '0);

   generate
      if (WORD_BITS <= ils_pkg::DATA_BITS) begin : g_narrow
         assign key_word = req_chan.value[WORD_BITS-1:0];
         assign rd_data  = ils_pkg::DATA_BITS'(rd_word);
      end else begin : g_wide
         assign key_word = WORD_BITS'(unsigned'(req_chan.value));
         assign rd_data  = rd_word[ils_pkg::DATA_BITS-1:0];
      end
   endgenerate

   always_comb begin
      op_c      = ils_pkg::SHIFT_HOLD;
      pos_c     = '0;
      status_in = ils_pkg::ST_OK;
      occ_in    = occ_ff;
      read_ok   = 1'b0;
      unique case (ils_pkg::kind_type'(req_chan.kind))
         ils_pkg::KIND_PUSH_FRONT, ils_pkg::KIND_PUSH_BACK: begin
            if (full) begin
               status_in = ils_pkg::ST_FULL;
            end else begin
               op_c   = ils_pkg::SHIFT_OPEN;
               pos_c  = (req_chan.kind == ils_pkg::KIND_PUSH_FRONT) ? '0 : occ_ext;
               occ_in = occ_ff + 1'b1;
            end
         end
         ils_pkg::KIND_INSERT: begin
            if (full) begin
               status_in = ils_pkg::ST_FULL;
            end else if (idx_ext > occ_ext) begin
               status_in = ils_pkg::ST_RANGE;
            end else begin
               op_c   = ils_pkg::SHIFT_OPEN;
               pos_c  = idx_ext;
               occ_in = occ_ff + 1'b1;
            end
         end
         ils_pkg::KIND_REMOVE_AT: begin
            if (idx_ext >= occ_ext) begin
               status_in = ils_pkg::ST_RANGE;
            end else begin
               op_c   = ils_pkg::SHIFT_CLOSE;
               pos_c  = idx_ext;
               occ_in = occ_ff - 1'b1;
            end
         end
         ils_pkg::KIND_POP_FRONT, ils_pkg::KIND_POP_BACK: begin
            if (empty) begin
               status_in = ils_pkg::ST_RANGE;
            end else begin
               op_c   = ils_pkg::SHIFT_CLOSE;
               pos_c  = (req_chan.kind == ils_pkg::KIND_POP_FRONT) ? '0
                                                                    : occ_ext - 1'b1;
               occ_in = occ_ff - 1'b1;
            end
         end
         ils_pkg::KIND_READ_AT: begin
            if (idx_ext >= occ_ext) begin
               status_in = ils_pkg::ST_RANGE;
            end else begin
               read_ok = 1'b1;
            end
         end
         ils_pkg::KIND_CONTAINS: begin
            status_in = ils_pkg::ST_OK;
         end
         ils_pkg::KIND_CLEAR: begin
            occ_in = '0;
         end
         default: begin
            status_in = ils_pkg::ST_OK;
         end
      endcase
   end

   assign cell_op = accept ? op_c : ils_pkg::SHIFT_HOLD;

   generate
      for (genvar i = 0; i < DEPTH; i++) begin : g_cell
         logic [WORD_BITS-1:0] left_word;
         logic [WORD_BITS-1:0] right_word;

         if (i == 0) begin : g_first
            assign left_word = '0;
         end else begin : g_mid_left
            assign left_word = cell_word[i-1];
         end

         if (i == DEPTH - 1) begin : g_last
            assign right_word = '0;
         end else begin : g_mid_right
            assign right_word = cell_word[i+1];
         end

         ils_cell #(
            .WORD_BITS (WORD_BITS),
            .POS_BITS  (CMP_BITS),
            .POS       (i)
         ) u_cell (
            .clock      (clock),
            .op         (cell_op),
            .pos        (pos_c),
            .occupancy  (occ_ext),
            .index      (idx_ext),
            .new_word   (key_word),
            .key        (key_word),
            .left_word  (left_word),
            .right_word (right_word),
            .word       (cell_word[i]),
            .status     (cell_stat[i])
         );
      end
   endgenerate

   always_comb begin
      rd_word = '0;
      any_eq  = 1'b0;
      for (int i = 0; i < DEPTH; i++) begin
         rd_word = rd_word | (cell_stat[i].sel ? cell_word[i] : '0);
         any_eq  = any_eq | cell_stat[i].eq;
      end
   end

   assign rsp_data_in  = read_ok ? signed'(rd_data) : '0;
   assign rsp_found_in = (req_chan.kind == ils_pkg::KIND_CONTAINS) && any_eq;

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            occ_ff       <= occ_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff   <= rsp_data_in;
         rsp_found_ff  <= rsp_found_in;
         rsp_count_ff  <= ils_pkg::COUNT_BITS'(occ_in);
         rsp_status_ff <= status_in;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.read_data = rsp_data_ff;
   assign rsp_chan.found     = rsp_found_ff;
   assign rsp_chan.count     = rsp_count_ff;
   assign rsp_chan.status    = rsp_status_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= FULL_COUNT)
      else $error("list count exceeds its depth");

   a_error_keeps_count: assert property (@(posedge clock) disable iff (reset)
      accept && (status_in != ils_pkg::ST_OK) |=> occ_ff == $past(occ_ff))
      else $error("rejected operation changed the list count");

   a_rsp_count_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_count_ff == ils_pkg::COUNT_BITS'(occ_ff))
      else $error("response count differs from the list count");

   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted request word produced no response word");

endmodule
